@@ hdl/flash_request_checker_page_splitter_core_assert.svh @@
// ----------------------------------------------------------------------------
// Flash request checker assertion macros
// Concurrent assertion shorthands, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef FLASH_REQUEST_CHECKER_PAGE_SPLITTER_CORE_ASSERT_SVH
`define FLASH_REQUEST_CHECKER_PAGE_SPLITTER_CORE_ASSERT_SVH

// same-cycle implication
`define FRCPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/frcps_pkg.sv @@
// ----------------------------------------------------------------------------
// Flash request checker package
// Sizes, codes, beat types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package frcps_pkg;

  localparam int FLASH_BYTES       = 33554432;
  localparam int PAGE_BYTES        = 256;
  localparam int SECTOR_BYTES      = 4096;
  localparam int MAX_PROGRAM_BYTES = 8192;
  localparam int RESULT_LIMIT      = 33;

  localparam int PAGE_LG   = $clog2(PAGE_BYTES);
  localparam int SECTOR_LG = $clog2(SECTOR_BYTES);
  localparam int ROOM_W    = PAGE_LG + 1;

  localparam logic [31:0] SRAM_LOW  = 32'h1800_0000;
  localparam logic [31:0] SRAM_HIGH = 32'h1804_0000;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_ERASE = 2'd1;
  localparam logic [1:0] MODE_PROG  = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_RANGE  = 3'd1;
  localparam logic [2:0] ST_ALIGN  = 3'd2;
  localparam logic [2:0] ST_LOCKED = 3'd3;
  localparam logic [2:0] ST_SOURCE = 3'd4;
  localparam logic [2:0] ST_LONG   = 3'd5;

  localparam logic [2:0] CFG_SCREEN_A     = 3'd0;
  localparam logic [2:0] CFG_SCREEN_B     = 3'd1;
  localparam logic [2:0] CFG_PROFILE_A    = 3'd2;
  localparam logic [2:0] CFG_PROFILE_B    = 3'd3;
  localparam logic [2:0] CFG_SCREEN_SIZE  = 3'd4;
  localparam logic [2:0] CFG_PROFILE_SIZE = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [25:0] offset;
    logic [25:0] length;
    logic [31:0] src_addr;
  } req_t;

  typedef struct packed {
    logic [25:0] chunk_offset;
    logic [25:0] chunk_length;
    logic [31:0] chunk_source;
    logic [2:0]  status;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       pre;
    logic       win;
    logic [1:0] win_idx;
    logic       emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_beat;
  } dp_stat_t;

endpackage

@@ hdl/flash_request_checker_page_splitter_core.sv @@
// ----------------------------------------------------------------------------
// Flash request checker and page splitter
// Checks read, sector erase and program requests against the flash size and
// four writable windows, and splits accepted programs into page chunks.
//
//   Channel  Handshake              Payload
//   req      req_valid / req_stall  req (mode, offset, length, src_addr)
//   rsp      rsp_valid / rsp_stall  rsp (chunk_offset, chunk_length, ...)
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request at a time: accept, pre-check, a scan of the four windows one at
// a time, then one result beat per cycle while rsp is not stalled, up to 33
// beats. rst is synchronous and clears config to zero. req_stall is high
// from accept until the last beat is loaded; a stalled rsp beat holds and
// the next beat waits in the controller.
// ----------------------------------------------------------------------------
module flash_request_checker_page_splitter_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  frcps_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output frcps_pkg::rsp_t   rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [25:0]       cfg_data
);
  import frcps_pkg::*;

  `include "flash_request_checker_page_splitter_core_assert.svh"

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  frcps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  frcps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `FRCPS_ASSERT_NOW(a_reject_is_last, rsp_valid && (rsp.status != ST_OK), rsp.last,
    "reject beat without last")
  `FRCPS_ASSERT_NOW(a_reject_empty, rsp_valid && (rsp.status != ST_OK),
    (rsp.chunk_length == '0) && (rsp.chunk_offset == '0), "reject beat carries payload")
  `FRCPS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
    "request side open right after accept")

endmodule

@@ hdl/frcps_ctrl.sv @@
// ----------------------------------------------------------------------------
// Flash request checker controller
// Sequences load, pre-check, window scan and chunk emission.
// ----------------------------------------------------------------------------
module frcps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  frcps_pkg::dp_stat_t  stat,
  output frcps_pkg::ctrl_cmd_t cmd
);
  import frcps_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PRE  = 2'd1;
  localparam logic [1:0] S_WIN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state, state_next;
  logic [1:0] win_idx, win_idx_next;

  always_comb begin
    state_next   = state;
    win_idx_next = win_idx;
    cmd          = '0;
    cmd.win_idx  = win_idx;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre      = 1'b1;
        win_idx_next = '0;
        state_next   = S_WIN;
      end
      S_WIN: begin
        cmd.win      = 1'b1;
        win_idx_next = win_idx + 2'd1;
        if (win_idx == 2'd3) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_beat) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      win_idx <= '0;
    end else begin
      state   <= state_next;
      win_idx <= win_idx_next;
    end
  end

  assign req_stall = (state != S_IDLE);

endmodule

@@ hdl/frcps_dp.sv @@
// ----------------------------------------------------------------------------
// Flash request checker datapath
// Config registers, request checks, window scan, page chunking, output beat.
// ----------------------------------------------------------------------------
module frcps_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  frcps_pkg::req_t      req,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [25:0]          cfg_data,
  input  frcps_pkg::ctrl_cmd_t cmd,
  output frcps_pkg::dp_stat_t  stat,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output frcps_pkg::rsp_t      rsp
);
  import frcps_pkg::*;

  logic [24:0] screen_a_start, screen_b_start, profile_a_start, profile_b_start;
  logic [25:0] screen_slot_bytes, profile_slot_bytes;

  logic [1:0]  mode;
  logic [25:0] off, len;
  logic [31:0] src;
  logic [25:0] cur_off, rem;
  logic [31:0] cur_src;
  logic [26:0] sum_end;
  logic        range_ok, align_ok, src_ok, long_ok, wr;

  logic [25:0] eff_len;
  logic [26:0] sum_c;
  logic [32:0] src_sum;
  logic [26:0] csum;
  logic [26:0] chunks;
  logic        range_c, src_c, long_c;
  logic [24:0] win_start;
  logic [25:0] win_size;
  logic [26:0] win_end;
  logic        win_hit;
  logic [2:0]  status;
  logic [ROOM_W-1:0] room;
  logic [25:0] cnt;
  logic        prog_last;
  rsp_t        rsp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_a_start     <= '0;
      screen_b_start     <= '0;
      profile_a_start    <= '0;
      profile_b_start    <= '0;
      screen_slot_bytes  <= '0;
      profile_slot_bytes <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCREEN_A:     screen_a_start     <= cfg_data[24:0];
        CFG_SCREEN_B:     screen_b_start     <= cfg_data[24:0];
        CFG_PROFILE_A:    profile_a_start    <= cfg_data[24:0];
        CFG_PROFILE_B:    profile_b_start    <= cfg_data[24:0];
        CFG_SCREEN_SIZE:  screen_slot_bytes  <= cfg_data;
        CFG_PROFILE_SIZE: profile_slot_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // pre-check
  assign eff_len = (mode == MODE_ERASE) ? 26'(SECTOR_BYTES) : len;
  assign sum_c   = {1'b0, off} + {1'b0, eff_len};
  assign range_c = (eff_len == '0) ? (32'(off) <= 32'(FLASH_BYTES))
                 : ((32'(off) < 32'(FLASH_BYTES)) && (32'(sum_c) <= 32'(FLASH_BYTES)));
  assign src_sum = {1'b0, src} + 33'(len);
  assign src_c   = (src >= SRAM_LOW) && (src < SRAM_HIGH) && (src_sum <= {1'b0, SRAM_HIGH});
  assign csum    = 27'(off[PAGE_LG-1:0]) + {1'b0, len} + 27'(PAGE_BYTES - 1);
  assign chunks  = csum >> PAGE_LG;
  assign long_c  = (len <= 26'(MAX_PROGRAM_BYTES)) && (chunks <= 27'(RESULT_LIMIT));

  // window scan
  always_comb begin
    case (cmd.win_idx)
      2'd0:    begin win_start = screen_a_start;  win_size = screen_slot_bytes;  end
      2'd1:    begin win_start = screen_b_start;  win_size = screen_slot_bytes;  end
      2'd2:    begin win_start = profile_a_start; win_size = profile_slot_bytes; end
      default: begin win_start = profile_b_start; win_size = profile_slot_bytes; end
    endcase
  end

  assign win_end = 27'(win_start) + {1'b0, win_size};
  assign win_hit = ({1'b0, off} >= 27'(win_start)) && ({1'b0, off} < win_end)
                 && (sum_end <= win_end);

  always_comb begin
    case (mode)
      MODE_READ:  status = range_ok ? ST_OK : ST_RANGE;
      MODE_ERASE: begin
        if (!align_ok)      status = ST_ALIGN;
        else if (!range_ok) status = ST_RANGE;
        else if (!wr)       status = ST_LOCKED;
        else                status = ST_OK;
      end
      MODE_PROG: begin
        if (!range_ok)                    status = ST_RANGE;
        else if (!wr || (len == '0))      status = ST_LOCKED;
        else if (!src_ok)                 status = ST_SOURCE;
        else if (!long_ok)                status = ST_LONG;
        else                              status = ST_OK;
      end
      default: status = ST_RANGE;
    endcase
  end

  // page chunking
  assign room      = ROOM_W'(PAGE_BYTES) - {1'b0, cur_off[PAGE_LG-1:0]};
  assign cnt       = (rem < 26'(room)) ? rem : 26'(room);
  assign prog_last = (rem <= 26'(room));

  assign stat.out_free  = !rsp_valid || !rsp_stall;
  assign stat.last_beat = (status != ST_OK) || (mode != MODE_PROG) || prog_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode    <= req.mode;
      off     <= req.offset;
      len     <= req.length;
      src     <= req.src_addr;
      cur_off <= req.offset;
      rem     <= req.length;
      cur_src <= req.src_addr;
    end else if (cmd.emit && (mode == MODE_PROG)) begin
      cur_off <= cur_off + cnt;
      cur_src <= cur_src + 32'(cnt);
      rem     <= rem - cnt;
    end
    if (cmd.pre) begin
      sum_end  <= sum_c;
      range_ok <= range_c;
      align_ok <= (off[SECTOR_LG-1:0] == '0);
      src_ok   <= src_c;
      long_ok  <= long_c;
      wr       <= 1'b0;
    end else if (cmd.win) begin
      wr <= wr | win_hit;
    end
  end

  always_comb begin
    rsp_next        = '0;
    rsp_next.status = status;
    rsp_next.last   = 1'b1;
    if (status == ST_OK) begin
      case (mode)
        MODE_READ: begin
          rsp_next.chunk_offset = off;
          rsp_next.chunk_length = len;
          rsp_next.chunk_source = src;
        end
        MODE_ERASE: begin
          rsp_next.chunk_offset = off;
          rsp_next.chunk_length = 26'(SECTOR_BYTES);
        end
        default: begin
          rsp_next.chunk_offset = cur_off;
          rsp_next.chunk_length = cnt;
          rsp_next.chunk_source = cur_src;
          rsp_next.last         = prog_last;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Flash request checker and page splitter testbench
// Drives read, erase and program requests through the core under several
// writable-window layouts. A directed table covers range ends, each status
// code and the 33-chunk program. Random requests follow, mostly aimed inside
// the configured windows. Each beat is checked against the table or a local
// model of the checks and the page split. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import frcps_pkg::*;

  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic [2:0] CFG_SPARE_A  = 3'd6;
  localparam logic [2:0] CFG_SPARE_B  = 3'd7;
  localparam int         IDLE_PCT     = 18;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         TAIL_CYCLES  = 48;
  localparam int         RANDOM_ROUNDS = 7;
  localparam int         ROUND_ITEMS  = 55;

  typedef logic [25:0] window_set_t [6];

  typedef struct {
    bit          grp;
    logic [1:0]  mode;
    logic [25:0] offset;
    logic [25:0] length;
    logic [31:0] src;
    bit          typed;
    logic [2:0]  status;
  } drill_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [25:0] cfg_data = '0;

  longint unsigned window_base [4];
  longint unsigned screen_span;
  longint unsigned profile_span;
  rsp_t pending_chunks [$];

  bit steady = 1'b0;
  int mismatch_count = 0;
  int beats_checked = 0;
  int rejects_seen = 0;
  int requests_sent = 0;
  int load_count = 0;
  int mode_tally [4] = '{0, 0, 0, 0};

  window_set_t split_windows = '{26'h0010000, 26'h1000000, 26'h1FF0000, 26'h0800000,
                                 26'h0020000, 26'h0010000};
  window_set_t edge_windows  = '{26'h0000000, 26'h3FFFFFF, 26'h1FFFFFF, 26'h2000000,
                                 26'h2000000, 26'h3FFFFFF};

  drill_t drill_table [26] = '{
    '{1'b0, MODE_READ,  26'h0000000, 26'h0000000, 32'h0000_0000, 1'b1, ST_OK},
    '{1'b0, MODE_READ,  26'h2000000, 26'h0000000, 32'h1234_5678, 1'b1, ST_OK},
    '{1'b0, MODE_READ,  26'h0000000, 26'h2000000, 32'hFFFF_FFFF, 1'b1, ST_OK},
    '{1'b0, MODE_READ,  26'h2000000, 26'h0000001, 32'h0000_0000, 1'b1, ST_RANGE},
    '{1'b0, MODE_READ,  26'h3FFFFFF, 26'h3FFFFFF, 32'hFFFF_FFFF, 1'b1, ST_RANGE},
    '{1'b0, MODE_READ,  26'h0000001, 26'h1FFFFFF, 32'hA5A5_5A5A, 1'b1, ST_OK},
    '{1'b0, MODE_SPARE, 26'h0000000, 26'h0000000, 32'h0000_0000, 1'b1, ST_RANGE},
    '{1'b0, MODE_ERASE, 26'h0000800, 26'h0000000, 32'h0000_0000, 1'b1, ST_ALIGN},
    '{1'b0, MODE_ERASE, 26'h2000000, 26'h3FFFFFF, 32'h0000_0000, 1'b1, ST_RANGE},
    '{1'b0, MODE_ERASE, 26'h1FFF000, 26'h0000000, 32'h0000_0000, 1'b1, ST_LOCKED},
    '{1'b0, MODE_PROG,  26'h0000000, 26'h0000000, SRAM_LOW,      1'b1, ST_LOCKED},
    '{1'b0, MODE_PROG,  26'h1FFFF00, 26'h0000101, SRAM_LOW,      1'b1, ST_RANGE},
    '{1'b1, MODE_ERASE, 26'h0010000, 26'h0000000, 32'hFFFF_FFFF, 1'b0, ST_OK},
    '{1'b1, MODE_ERASE, 26'h002F000, 26'h0000000, 32'h0000_0000, 1'b0, ST_OK},
    '{1'b1, MODE_ERASE, 26'h0030000, 26'h0000000, 32'h0000_0000, 1'b1, ST_LOCKED},
    '{1'b1, MODE_ERASE, 26'h1FFF000, 26'h0000000, 32'h0000_0000, 1'b0, ST_OK},
    '{1'b1, MODE_PROG,  26'h0010080, 26'h0002000, SRAM_LOW,      1'b0, ST_OK},
    '{1'b1, MODE_PROG,  26'h0010000, 26'h0002001, SRAM_LOW,      1'b1, ST_LONG},
    '{1'b1, MODE_PROG,  26'h0010000, 26'h0000010, 32'h17FF_FFFF, 1'b1, ST_SOURCE},
    '{1'b1, MODE_PROG,  26'h0010000, 26'h0000010, SRAM_HIGH,     1'b1, ST_SOURCE},
    '{1'b1, MODE_PROG,  26'h0010000, 26'h0000010, SRAM_HIGH - 32'h10, 1'b0, ST_OK},
    '{1'b1, MODE_PROG,  26'h0010000, 26'h0000011, SRAM_HIGH - 32'h10, 1'b1, ST_SOURCE},
    '{1'b1, MODE_PROG,  26'h002FFFF, 26'h0000002, SRAM_LOW,      1'b1, ST_LOCKED},
    '{1'b1, MODE_PROG,  26'h1FFFFFF, 26'h0000001, SRAM_LOW + 32'h100, 1'b0, ST_OK},
    '{1'b1, MODE_PROG,  26'h1000000, 26'h0020000, SRAM_LOW,      1'b1, ST_LONG},
    '{1'b1, MODE_PROG,  26'h08000F0, 26'h0000020, SRAM_LOW + 32'h7, 1'b0, ST_OK}
  };

  flash_request_checker_page_splitter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void store_register(input logic [2:0] idx, input logic [25:0] data);
    case (idx)
      CFG_SCREEN_A:     window_base[0] = data[24:0];
      CFG_SCREEN_B:     window_base[1] = data[24:0];
      CFG_PROFILE_A:    window_base[2] = data[24:0];
      CFG_PROFILE_B:    window_base[3] = data[24:0];
      CFG_SCREEN_SIZE:  screen_span = data;
      CFG_PROFILE_SIZE: profile_span = data;
      default: ;
    endcase
  endfunction

  function automatic bit fits_flash(input longint unsigned off, input longint unsigned len);
    if (len == 0) return off <= FLASH_BYTES;
    return off < FLASH_BYTES && len <= FLASH_BYTES - off;
  endfunction

  function automatic bit in_window(input longint unsigned off, input longint unsigned len,
                                   input longint unsigned base, input longint unsigned span);
    longint unsigned stop;
    stop = base + span;
    return off >= base && off < stop && len <= stop - off;
  endfunction

  function automatic bit writable_span(input longint unsigned off, input longint unsigned len);
    if (len == 0) return 1'b0;
    return in_window(off, len, window_base[0], screen_span) ||
           in_window(off, len, window_base[1], screen_span) ||
           in_window(off, len, window_base[2], profile_span) ||
           in_window(off, len, window_base[3], profile_span);
  endfunction

  function automatic void forecast_chunks(input req_t r);
    longint unsigned off, len, src, cur, cnt, room;
    logic [2:0] verdict;
    int n;
    off = r.offset;
    len = r.length;
    src = r.src_addr;
    verdict = ST_OK;
    case (r.mode)
      MODE_READ: if (!fits_flash(off, len)) verdict = ST_RANGE;
      MODE_ERASE: begin
        if (off % SECTOR_BYTES != 0) verdict = ST_ALIGN;
        else if (!fits_flash(off, SECTOR_BYTES)) verdict = ST_RANGE;
        else if (!writable_span(off, SECTOR_BYTES)) verdict = ST_LOCKED;
      end
      MODE_PROG: begin
        if (!fits_flash(off, len)) verdict = ST_RANGE;
        else if (!writable_span(off, len)) verdict = ST_LOCKED;
        else if (src < SRAM_LOW || src >= SRAM_HIGH || len > SRAM_HIGH - src)
          verdict = ST_SOURCE;
        else if (len > MAX_PROGRAM_BYTES) verdict = ST_LONG;
        else if ((off % PAGE_BYTES + len + PAGE_BYTES - 1) / PAGE_BYTES > RESULT_LIMIT)
          verdict = ST_LONG;
      end
      default: verdict = ST_RANGE;
    endcase
    if (verdict != ST_OK) begin
      pending_chunks.push_back(rsp_t'{26'd0, 26'd0, 32'd0, verdict, 1'b1});
    end else if (r.mode == MODE_READ) begin
      pending_chunks.push_back(rsp_t'{r.offset, r.length, r.src_addr, ST_OK, 1'b1});
    end else if (r.mode == MODE_ERASE) begin
      pending_chunks.push_back(rsp_t'{r.offset, 26'(SECTOR_BYTES), 32'd0, ST_OK, 1'b1});
    end else begin
      cur = 0;
      n = 0;
      while (cur < len && n < RESULT_LIMIT) begin
        room = PAGE_BYTES - ((off + cur) % PAGE_BYTES);
        cnt = (len - cur > room) ? room : len - cur;
        pending_chunks.push_back(rsp_t'{26'(off + cur), 26'(cnt), 32'(src + cur), ST_OK,
                                        cur + cnt >= len});
        cur += cnt;
        n++;
      end
    end
  endfunction

  // mostly requests aimed into a configured window; some are reads anywhere in flash, the rest raw noise
  function automatic req_t compose_request();
    req_t r;
    int unsigned pick, w;
    longint unsigned base, span, off, len;
    pick = $urandom_range(0, 99);
    r.mode = 2'($urandom);
    r.offset = 26'($urandom);
    r.length = 26'($urandom);
    r.src_addr = $urandom;
    if (pick < 22) return r;
    w = $urandom_range(0, 3);
    base = window_base[w];
    span = (w < 2) ? screen_span : profile_span;
    if (pick < 40) begin
      r.mode = MODE_READ;
      off = $urandom_range(0, FLASH_BYTES);
      len = ($urandom_range(0, 3) == 0) ? FLASH_BYTES - off : $urandom_range(0, 4096);
      r.offset = 26'(off);
      r.length = 26'(len);
    end else if (pick < 65) begin
      r.mode = MODE_ERASE;
      off = base + ((span > 0) ? $urandom % span : 0);
      if ($urandom_range(0, 9) != 0) off = off & ~64'hFFF;
      r.offset = 26'(off);
    end else begin
      r.mode = MODE_PROG;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8300) : $urandom_range(1, 600);
      off = base + ((span > len) ? $urandom % (span - len + 1) : 0);
      r.offset = 26'(off);
      r.length = 26'(len);
      if ($urandom_range(0, 9) != 0)
        r.src_addr = SRAM_LOW + $urandom_range(0, 32'h40000 - 32'(len));
    end
    return r;
  endfunction

  function automatic void report_fault(input string what, input rsp_t want, input rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected off=%h len=%h src=%h st=%0d last=%0b, ",
               what, want.chunk_offset, want.chunk_length, want.chunk_source, want.status,
               want.last,
               "got off=%h len=%h src=%h st=%0d last=%0b",
               got.chunk_offset, got.chunk_length, got.chunk_source, got.status, got.last);
  endfunction

  task automatic issue_request(input req_t r);
    int gap;
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = $urandom_range(1, 8);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    requests_sent++;
    mode_tally[r.mode]++;
  endtask

  task automatic drain_pipeline();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_chunks.size() != 0);
  endtask

  task automatic load_windows(input window_set_t vals);
    logic [2:0] idx;
    logic [25:0] data;
    for (int i = 0; i <= int'(CFG_PROFILE_SIZE) + 1; i++) begin
      if (i > int'(CFG_PROFILE_SIZE)) begin
        idx = load_count[0] ? CFG_SPARE_B : CFG_SPARE_A;
        data = 26'($urandom);
      end else begin
        idx = 3'(i);
        data = vals[i];
      end
      cfg_index <= idx;
      cfg_data <= data;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      store_register(idx, data);
    end
    cfg_valid <= 1'b0;
    load_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      beats_checked++;
      if (rsp.status != ST_OK) rejects_seen++;
      if (pending_chunks.size() == 0) begin
        report_fault("unexpected beat", '0, rsp);
      end else if (rsp.chunk_offset !== pending_chunks[0].chunk_offset ||
                   rsp.chunk_length !== pending_chunks[0].chunk_length ||
                   rsp.chunk_source !== pending_chunks[0].chunk_source ||
                   rsp.status !== pending_chunks[0].status ||
                   rsp.last !== pending_chunks[0].last) begin
        report_fault("beat mismatch", pending_chunks.pop_front(), rsp);
      end else begin
        void'(pending_chunks.pop_front());
      end
    end
    rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("flash_request_checker_page_splitter_core verification failed");
    $finish;
  end

  initial begin : stimulus
    req_t item;
    window_set_t plan;
    bit loaded;
    loaded = 1'b0;
    for (int i = 0; i < 4; i++) window_base[i] = 0;
    screen_span = 0;
    profile_span = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (drill_table[k]) begin
      if (drill_table[k].grp && !loaded) begin
        drain_pipeline();
        load_windows(split_windows);
        loaded = 1'b1;
      end
      item = '{drill_table[k].mode, drill_table[k].offset, drill_table[k].length,
               drill_table[k].src};
      issue_request(item);
      if (!drill_table[k].typed)
        forecast_chunks(item);
      else if (drill_table[k].status == ST_OK)
        pending_chunks.push_back(rsp_t'{item.offset, item.length, item.src_addr,
                                        ST_OK, 1'b1});
      else
        pending_chunks.push_back(rsp_t'{26'd0, 26'd0, 32'd0, drill_table[k].status, 1'b1});
    end

    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      drain_pipeline();
      case (round)
        0: plan = edge_windows;
        1: plan = split_windows;
        default: begin
          for (int i = 0; i < 4; i++)
            plan[i] = ($urandom_range(0, 3) == 0) ? 26'($urandom)
                                                  : 26'($urandom_range(0, 'h1FFF) << 12);
          for (int i = 4; i < 6; i++)
            plan[i] = (round == 2) ? 26'd0 :
                      ($urandom_range(0, 5) == 0) ? 26'($urandom)
                                                  : 26'($urandom_range(1, 64) << 12);
        end
      endcase
      load_windows(plan);
      steady = (round == 3);
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) drain_pipeline();
        item = compose_request();
        issue_request(item);
        forecast_chunks(item);
      end
      steady = 1'b0;
    end

    drain_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk);
    while (pending_chunks.size() != 0)
      report_fault("beat never arrived", pending_chunks.pop_front(), '0);

    $display("Summary: %0d requests over %0d window loads, %0d beats checked, %0d rejects",
             requests_sent, load_count, beats_checked, rejects_seen);
    $display("Summary: mode mix read %0d, erase %0d, program %0d, unused %0d; %0d mismatches",
             mode_tally[0], mode_tally[1], mode_tally[2], mode_tally[3], mismatch_count);
    if (mismatch_count == 0)
      $display("flash_request_checker_page_splitter_core verification clean");
    else
      $display("flash_request_checker_page_splitter_core verification failed");
    $finish;
  end

endmodule

@@ flash_request_checker_page_splitter_core.f @@
+incdir+hdl
hdl/frcps_pkg.sv
hdl/frcps_ctrl.sv
hdl/frcps_dp.sv
hdl/flash_request_checker_page_splitter_core.sv
bench/testbench.sv
